// ----- hw/rtl/fa2_pkg.sv -----
// shared constants and types for the four-quadrant arctangent block
package fa2_pkg;

  localparam int ANGLE_W = 16;
  localparam int A_W     = 17;
  localparam int Q_FRAC  = 16;

  localparam logic [29:0] C1_Q30      = 30'd351782264;
  localparam logic [29:0] C2_Q30      = 30'd171062341;
  localparam logic [29:0] C3_Q30      = 30'd49925210;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629759;
  localparam logic [31:0] PI_Q30      = 32'd3373259519;

  localparam logic [A_W-1:0] A_ONE = 17'd65536;

  typedef struct packed {
    logic zero;
    logic xneg;
    logic yneg;
    logic swap;
  } meta_t;

  localparam int META_W = $bits(meta_t);

endpackage

// ----- hw/rtl/fa2_if.sv -----
// coordinate and angle channel interfaces
interface fa2_in_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] coord_x;
  logic signed [W-1:0] coord_y;

  modport source (output valid, coord_x, coord_y, input ready);
  modport sink (input valid, coord_x, coord_y, output ready);
endinterface

interface fa2_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle;
  logic               both_zero;

  modport source (output valid, angle, both_zero, input ready);
  modport sink (input valid, angle, both_zero, output ready);
endinterface

// ----- hw/rtl/fa2_front.sv -----
// front end: magnitudes, octant classification and min/max ordering
module fa2_front import fa2_pkg::*; #(
  parameter int W = 16
) (
  input  logic [W-1:0] coord_x_i,
  input  logic [W-1:0] coord_y_i,
  output meta_t        meta_o,
  output logic [W-1:0] mn_o,
  output logic [W-1:0] mx_o
);

  logic [W-1:0] ax, ay;

  always_comb begin
    ax = coord_x_i[W-1] ? (~coord_x_i + W'(1)) : coord_x_i;
    ay = coord_y_i[W-1] ? (~coord_y_i + W'(1)) : coord_y_i;
    meta_o.xneg = coord_x_i[W-1];
    meta_o.yneg = coord_y_i[W-1];
    meta_o.swap = ay > ax;
    meta_o.zero = (ax == '0) && (ay == '0);
    mn_o = meta_o.swap ? ax : ay;
    mx_o = meta_o.swap ? ay : ax;
  end

endmodule

// ----- hw/rtl/fa2_fifo.sv -----
// two-entry queue between front and back end
module fa2_fifo #(
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] mem_q [2];
  logic              wr_q, wr_d, rd_q, rd_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              do_pop;

  always_comb begin
    do_pop  = pop_i && (cnt_q != 2'd0);
    full_o  = cnt_q == 2'd2;
    valid_o = cnt_q != 2'd0;
    data_o  = mem_q[rd_q];
    wr_d    = push_i ? ~wr_q : wr_q;
    rd_d    = do_pop ? ~rd_q : rd_q;
    cnt_d   = cnt_q + 2'(push_i) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- hw/rtl/fa2_back.sv -----
// back end: pipelined divider, polynomial and octant fold
module fa2_back import fa2_pkg::*; #(
  parameter int W = 16,
  parameter int F = 13
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  meta_t              meta_i,
  input  logic [W-1:0]       mn_i,
  input  logic [W-1:0]       mx_i,
  output logic               ready_o,
  output logic               valid_o,
  input  logic               ready_i,
  output logic signed [15:0] angle_o,
  output logic               both_zero_o
);

  localparam int NUM_W = W + A_W;
  localparam int REM_W = W + 1;

  logic en;

  logic [A_W:0]       dv_q;
  meta_t              dm_q [A_W+1];
  logic [W-1:0]       dx_q [A_W+1];
  logic [W-1:0]       dr_q [A_W+1];
  logic [NUM_W-1:0]   dn_q [A_W+1];
  logic [A_W-1:0]     dq_q [A_W+1];

  logic [NUM_W-1:0]   num0;

  assign en      = !valid_o || ready_i;
  assign ready_o = en;
  assign num0    = (NUM_W'(mn_i) << Q_FRAC) + NUM_W'(mx_i >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dm_q[0] <= meta_i;
      dx_q[0] <= mx_i;
      dr_q[0] <= W'(num0 >> A_W);
      dn_q[0] <= num0;
      dq_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < A_W; i++) begin : g_div
    logic [REM_W-1:0] trial;
    logic             ge;
    logic [REM_W-1:0] diff;

    always_comb begin
      trial = {dr_q[i], dn_q[i][A_W-1-i]};
      ge    = trial >= {1'b0, dx_q[i]};
      diff  = trial - {1'b0, dx_q[i]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[i+1] <= 1'b0;
      end else if (en) begin
        dv_q[i+1] <= dv_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dm_q[i+1] <= dm_q[i];
        dx_q[i+1] <= dx_q[i];
        dr_q[i+1] <= ge ? diff[W-1:0] : trial[W-1:0];
        dn_q[i+1] <= dn_q[i];
        dq_q[i+1] <= {dq_q[i][A_W-2:0], ge};
      end
    end
  end

  // polynomial stages
  logic [6:1]     pv_q;
  meta_t          pm_q [1:6];
  logic [A_W-1:0] a1_q, a2_q, a3_q, a4_q;
  logic [A_W-1:0] s1_q, s2_q, s3_q;
  logic [29:0]    t2_q, q3_q, w4_q;
  logic [30:0]    r5_q;
  logic [31:0]    r6_q;

  logic [A_W-1:0] a0;
  logic [33:0]    prod_aa;
  logic [46:0]    prod_c3s, prod_ts, prod_qs, prod_wa;
  logic [31:0]    fold1, fold2;
  logic [32:0]    rnd;
  logic [15:0]    mag, res;

  always_comb begin
    a0       = (dq_q[A_W] > A_ONE) ? A_ONE : dq_q[A_W];
    prod_aa  = 34'(a0) * 34'(a0);
    prod_c3s = 47'(C3_Q30) * 47'(s1_q);
    prod_ts  = 47'(t2_q) * 47'(s2_q);
    prod_qs  = 47'(q3_q) * 47'(s3_q);
    prod_wa  = 47'(w4_q) * 47'(a4_q);
    fold1    = pm_q[5].swap ? (HALF_PI_Q30 - 32'(r5_q)) : 32'(r5_q);
    fold2    = pm_q[5].xneg ? (PI_Q30 - fold1) : fold1;
    rnd      = (33'(r6_q) + (33'd1 << (29 - F))) >> (30 - F);
    mag      = rnd[15:0];
    res      = pm_q[6].yneg ? (16'd0 - mag) : mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q    <= '0;
      valid_o <= 1'b0;
    end else if (en) begin
      pv_q    <= {pv_q[5:1], dv_q[A_W]};
      valid_o <= pv_q[6];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pm_q[1] <= dm_q[A_W];
      pm_q[2] <= pm_q[1];
      pm_q[3] <= pm_q[2];
      pm_q[4] <= pm_q[3];
      pm_q[5] <= pm_q[4];
      pm_q[6] <= pm_q[5];
      a1_q    <= a0;
      s1_q    <= A_W'(prod_aa >> Q_FRAC);
      a2_q    <= a1_q;
      s2_q    <= s1_q;
      t2_q    <= C2_Q30 - 30'(prod_c3s >> Q_FRAC);
      a3_q    <= a2_q;
      s3_q    <= s2_q;
      q3_q    <= C1_Q30 - 30'(prod_ts >> Q_FRAC);
      a4_q    <= a3_q;
      w4_q    <= 30'(prod_qs >> Q_FRAC);
      r5_q    <= (31'(a4_q) << 14) - 31'(prod_wa >> Q_FRAC);
      r6_q    <= fold2;
      angle_o     <= pm_q[6].zero ? 16'sd0 : signed'(res);
      both_zero_o <= pm_q[6].zero;
    end
  end

endmodule

// ----- hw/rtl/fast_atan2_approx.sv -----
// top level of the four-quadrant arctangent block
// throughput: one beat per cycle without stall; each divider and polynomial stage is pipelined
// the front queue holds two beats; an output stall freezes the back end and
// the input stalls once the queue is full
// reset: asynchronous active low, clears queue and all stage valid flags
module fast_atan2_approx import fa2_pkg::*; #(
  parameter int COORD_BITS      = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fa2_in_if.sink    in_i,
  fa2_out_if.source out_o
);

  localparam int Q_W = META_W + 2 * COORD_BITS;

  meta_t                 f_meta, b_meta;
  logic [COORD_BITS-1:0] f_mn, f_mx, b_mn, b_mx;
  logic                  full, q_valid, b_ready, push;
  logic [Q_W-1:0]        q_out;

  fa2_front #(.W(COORD_BITS)) u_front (
    .coord_x_i (in_i.coord_x),
    .coord_y_i (in_i.coord_y),
    .meta_o    (f_meta),
    .mn_o      (f_mn),
    .mx_o      (f_mx)
  );

  assign in_i.ready = !full;
  assign push       = in_i.valid && !full;

  fa2_fifo #(.DATA_W(Q_W)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_meta, f_mn, f_mx}),
    .full_o  (full),
    .pop_i   (b_ready),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  assign {b_meta, b_mn, b_mx} = q_out;

  fa2_back #(.W(COORD_BITS), .F(ANGLE_FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .meta_i      (b_meta),
    .mn_i        (b_mn),
    .mx_i        (b_mx),
    .ready_o     (b_ready),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .angle_o     (out_o.angle),
    .both_zero_o (out_o.both_zero)
  );

endmodule

// ----- hw/rtl/fa2_checker.sv -----
// port-level checks for the arctangent block and their binding
module fa2_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] angle_i,
  input logic        both_zero_i
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(angle_i) && $stable(both_zero_i))
    else $error("result beat changed while stalled");

  a_zero_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && both_zero_i |-> angle_i == 16'd0)
    else $error("zero input gave nonzero angle");

  a_reset_quiet: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !out_valid_i)
    else $error("result beat right after reset");

endmodule

bind fast_atan2_approx fa2_checker u_fa2_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .angle_i     (out_o.angle),
  .both_zero_i (out_o.both_zero)
);
